FILE: rtl/mpd_pkg.sv
// package: widths, constants, state and control types of the masked patch distance block
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    localparam int IMG_DIM_W  = 11;
    localparam int WIN_W      = 4;
    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int DIST_W     = 17;
    localparam int OFFSET_W   = 8;
    localparam int WACC_W     = 33;
    localparam int WSUM_W     = 15;
    localparam int DEN_W      = 33;
    localparam int DIV_W      = 50;
    localparam int QUO_W      = 18;
    localparam int CNT_W      = 5;
    localparam int SQ_W       = 18;
    localparam int TERM_W     = 25;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DEFAULT_MAX_WINDOW = 15;
    localparam int DEFAULT_MAX_DIM    = 1024;

    localparam int DIV_STEPS = QUO_W;
    localparam int RS_STEPS  = OFFSET_W;

    localparam logic [SQ_W-1:0]       FULL_PENALTY    = 18'd195075;
    localparam logic [6:0]            HIGH_WEIGHT     = 7'd100;
    localparam logic [DIST_W-1:0]     DIST_ONE        = 17'd65536;
    localparam logic [IMG_DIM_W-1:0]  RST_IMAGE_DIM   = 11'd1024;
    localparam logic [WIN_W-1:0]      RST_PATCH_SIDE  = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_SIDE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DEN,
        ST_PREP,
        ST_DIV,
        ST_FINISH,
        ST_RS_DIV,
        ST_RS_APPLY
    } t_state;

    typedef struct packed {
        logic accept;
        logic accum;
        logic den_load;
        logic div_load;
        logic div_step;
        logic out_load;
        logic rs_load;
        logic rs_apply;
    } t_cmd;

    typedef struct packed {
        logic rs_pending;
        logic last;
        logic empty;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/mpd_ctrl.sv
// controller: sequences accumulation, final division and offset resync
`timescale 1ns / 1ps
`default_nettype none

module mpd_ctrl
    import mpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_status.rs_pending) begin
                    o_cmd.rs_load = 1'b1;
                    n_cnt         = '0;
                    n_state       = ST_RS_DIV;
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = ST_ACCUM;
                    end
                end
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last ? ST_DEN : ST_IDLE;
            end
            ST_DEN: begin
                o_cmd.den_load = 1'b1;
                n_state        = i_status.empty ? ST_FINISH : ST_PREP;
            end
            ST_PREP: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_RS_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(RS_STEPS - 1)) begin
                    n_state = ST_RS_APPLY;
                end
            end
            ST_RS_APPLY: begin
                o_cmd.rs_apply = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/mpd_datapath.sv
// datapath: config registers, offset walk, bounds and color terms, sums, divider, output register
`timescale 1ns / 1ps
`default_nettype none

module mpd_datapath
    import mpd_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
    parameter int MAX_DIM    = DEFAULT_MAX_DIM
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [COORD_W-1:0]    i_source_x,
    input  wire logic [COORD_W-1:0]    i_source_y,
    input  wire logic [COORD_W-1:0]    i_target_x,
    input  wire logic [COORD_W-1:0]    i_target_y,
    input  wire logic                  i_source_in_mask,
    input  wire logic                  i_target_in_mask,
    input  wire logic                  i_confident,
    input  wire logic [COLOR_W-1:0]    i_source_color,
    input  wire logic [COLOR_W-1:0]    i_target_color,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [DIST_W-1:0]          o_distance,
    output logic                       o_empty_window,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status
);

    localparam int CAP      = ((MAX_WINDOW - 1) / 2) * 2 + 1;
    localparam int SIDE_MAX = (CAP > 15) ? 15 : CAP;
    localparam int SIDE_W   = $clog2(SIDE_MAX + 1);
    localparam int DIM_CAP  = (MAX_DIM > 2047) ? 2047 : MAX_DIM;

    function automatic logic [15:0] sq_chan(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    function automatic logic in_bounds(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                       input logic [IMG_DIM_W-1:0] w,
                                       input logic [IMG_DIM_W-1:0] h);
        return !x[POS_W-1] && !y[POS_W-1] && (x[IMG_DIM_W-1:0] < w) && (y[IMG_DIM_W-1:0] < h);
    endfunction

    // configuration
    logic [IMG_DIM_W-1:0] r_image_width;
    logic [IMG_DIM_W-1:0] r_image_height;
    logic [WIN_W-1:0]     r_patch_side;
    logic                 r_rs_pending;

    // offset walk
    logic [OFFSET_W-1:0]  r_offset;
    logic [SIDE_W-1:0]    r_col;
    logic [SIDE_W-1:0]    r_row;

    // item stage
    logic [SQ_W-1:0]      r_sq;
    logic                 r_t_ok;
    logic                 r_s_ok;
    logic                 r_conf;
    logic                 r_last;

    // sums and divider
    logic [WACC_W-1:0]    r_wacc;
    logic [WSUM_W-1:0]    r_wsum;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dsh;
    logic [QUO_W-1:0]     r_q;

    // output register
    logic                 r_out_valid;
    logic [DIST_W-1:0]    r_distance;
    logic                 r_empty;

    logic [WIN_W-1:0]     n_wm1;
    logic [WIN_W-1:0]     n_side4;
    logic [SIDE_W-1:0]    n_side;
    logic [SIDE_W-1:0]    n_half;
    logic [15:0]          n_count;
    logic                 n_over;
    logic                 n_last;
    logic [SIDE_W-1:0]    n_col_eff;
    logic [SIDE_W-1:0]    n_row_eff;
    logic [IMG_DIM_W-1:0] n_w_eff;
    logic [IMG_DIM_W-1:0] n_h_eff;
    logic [POS_W-1:0]     n_sx;
    logic [POS_W-1:0]     n_sy;
    logic [POS_W-1:0]     n_tx;
    logic [POS_W-1:0]     n_ty;
    logic [SQ_W-1:0]      n_sq;
    logic [SQ_W-1:0]      n_val;
    logic [TERM_W-1:0]    n_term;
    logic [DIV_W:0]       n_sub;
    logic                 n_ge;
    logic                 n_q_sat;

    always_comb begin
        n_wm1   = r_patch_side - WIN_W'(1);
        n_side4 = (r_patch_side == '0) ? WIN_W'(1) : {n_wm1[WIN_W-1:1], 1'b1};
        n_side  = (32'(n_side4) > SIDE_MAX) ? SIDE_W'(SIDE_MAX) : SIDE_W'(n_side4);
        n_half  = (n_side - SIDE_W'(1)) >> 1;
        n_count = 16'(n_side) * 16'(n_side);
        n_over  = 16'(r_offset) >= n_count;
        n_last  = (16'(r_offset) + 16'd1) >= n_count;

        n_col_eff = n_over ? (n_side - SIDE_W'(1)) : r_col;
        n_row_eff = n_over ? (n_side - SIDE_W'(1)) : r_row;

        n_w_eff = (32'(r_image_width) > DIM_CAP) ? IMG_DIM_W'(DIM_CAP) : r_image_width;
        n_h_eff = (32'(r_image_height) > DIM_CAP) ? IMG_DIM_W'(DIM_CAP) : r_image_height;

        n_sx = POS_W'(i_source_x) + POS_W'(n_col_eff) - POS_W'(n_half);
        n_sy = POS_W'(i_source_y) + POS_W'(n_row_eff) - POS_W'(n_half);
        n_tx = POS_W'(i_target_x) + POS_W'(n_col_eff) - POS_W'(n_half);
        n_ty = POS_W'(i_target_y) + POS_W'(n_row_eff) - POS_W'(n_half);

        n_sq = SQ_W'(sq_chan(i_source_color[7:0],   i_target_color[7:0]))
             + SQ_W'(sq_chan(i_source_color[15:8],  i_target_color[15:8]))
             + SQ_W'(sq_chan(i_source_color[23:16], i_target_color[23:16]));

        n_val  = r_s_ok ? r_sq : FULL_PENALTY;
        n_term = r_conf ? (TERM_W'(n_val) * TERM_W'(HIGH_WEIGHT)) : TERM_W'(n_val);

        n_sub = {1'b0, r_rem} - {1'b0, r_dsh};
        n_ge  = !n_sub[DIV_W];

        n_q_sat = r_q[QUO_W-1] || (r_q[DIST_W-1:0] > DIST_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_DIM;
            r_image_height <= RST_IMAGE_DIM;
            r_patch_side   <= RST_PATCH_SIDE;
            r_rs_pending   <= 1'b0;
        end else begin
            r_rs_pending <= (r_rs_pending && !i_cmd.rs_load)
                         || (i_cfg_valid && (i_cfg_index == CFG_PATCH_SIDE));
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    CFG_PATCH_SIDE:   r_patch_side   <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cmd.accept) begin
            if (n_last) begin
                r_offset <= '0;
                r_col    <= '0;
                r_row    <= '0;
            end else begin
                r_offset <= r_offset + OFFSET_W'(1);
                if (r_col == n_side - SIDE_W'(1)) begin
                    r_col <= '0;
                    r_row <= r_row + SIDE_W'(1);
                end else begin
                    r_col <= r_col + SIDE_W'(1);
                end
            end
        end else if (i_cmd.rs_apply) begin
            r_row <= r_q[SIDE_W-1:0];
            r_col <= r_rem[SIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sq   <= n_sq;
            r_t_ok <= in_bounds(n_tx, n_ty, n_w_eff, n_h_eff) && i_target_in_mask;
            r_s_ok <= in_bounds(n_sx, n_sy, n_w_eff, n_h_eff) && i_source_in_mask;
            r_conf <= i_confident;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wacc <= '0;
            r_wsum <= '0;
        end else if (i_cmd.out_load) begin
            r_wacc <= '0;
            r_wsum <= '0;
        end else if (i_cmd.accum && r_t_ok) begin
            r_wacc <= r_wacc + WACC_W'(n_term);
            r_wsum <= r_wsum + (r_conf ? WSUM_W'(HIGH_WEIGHT) : WSUM_W'(1));
        end
    end

    // shared restoring divider: final quotient and offset resync
    always_ff @(posedge i_clk) begin
        if (i_cmd.den_load) begin
            r_den <= DEN_W'(FULL_PENALTY) * DEN_W'(r_wsum);
        end
        if (i_cmd.div_load) begin
            r_rem <= DIV_W'({r_wacc, 16'b0}) + DIV_W'(r_den[DEN_W-1:1]);
            r_dsh <= DIV_W'({r_den, 17'b0});
            r_q   <= '0;
        end else if (i_cmd.rs_load) begin
            r_rem <= DIV_W'(r_offset);
            r_dsh <= DIV_W'(n_side) << (OFFSET_W - 1);
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (n_ge) begin
                r_rem <= n_sub[DIV_W-1:0];
            end
            r_q   <= {r_q[QUO_W-2:0], n_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_empty    <= (r_wsum == '0);
            r_distance <= ((r_wsum == '0) || n_q_sat) ? DIST_ONE : r_q[DIST_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_distance     = r_distance;
    assign o_empty_window = r_empty;

    assign o_status.rs_pending = r_rs_pending;
    assign o_status.last       = r_last;
    assign o_status.empty      = (r_wsum == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

FILE: rtl/masked_patch_distance_top.sv
// top level: masked confidence-weighted patch distance over one window
//
//  channel | direction | signals                                   | transfer when
//  in      | input     | i_in_valid, o_in_ready, nine field ports  | i_in_valid & o_in_ready
//  out     | output    | o_out_valid, i_out_ready, distance, empty | o_out_valid & i_out_ready
//  cfg     | input     | i_cfg_valid, o_cfg_ready, index, data     | i_cfg_valid & o_cfg_ready
//
//  an offset item: capture of bounds and color terms, then accumulate, input held off
//  after the last offset: denominator multiply, load, 18-step restoring divider, output
//  load (only denominator multiply and output load when nothing counted)
//  a patch side write holds off the next item for the resync: load, 8-step resync, apply
//  the result sits in an output register; the load waits while that is full and unread
//  synchronous active-low reset clears the walk, sums and output valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module masked_patch_distance_top
    import mpd_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
    parameter int MAX_DIM    = DEFAULT_MAX_DIM
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [COORD_W-1:0]    i_source_x,
    input  wire logic [COORD_W-1:0]    i_source_y,
    input  wire logic [COORD_W-1:0]    i_target_x,
    input  wire logic [COORD_W-1:0]    i_target_y,
    input  wire logic                  i_source_in_mask,
    input  wire logic                  i_target_in_mask,
    input  wire logic                  i_confident,
    input  wire logic [COLOR_W-1:0]    i_source_color,
    input  wire logic [COLOR_W-1:0]    i_target_color,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [DIST_W-1:0]          o_distance,
    output logic                       o_empty_window
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    mpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mpd_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_DIM    (MAX_DIM)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_source_x       (i_source_x),
        .i_source_y       (i_source_y),
        .i_target_x       (i_target_x),
        .i_target_y       (i_target_y),
        .i_source_in_mask (i_source_in_mask),
        .i_target_in_mask (i_target_in_mask),
        .i_confident      (i_confident),
        .i_source_color   (i_source_color),
        .i_target_color   (i_target_color),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_distance       (o_distance),
        .o_empty_window   (o_empty_window),
        .i_cmd            (w_cmd),
        .o_status         (w_status)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again before accumulation");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result valid without a load");

    a_empty_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_window) |-> (o_distance == DIST_ONE))
        else $error("empty window with distance other than one");

endmodule

`default_nettype wire
